// ===== rtl/core/vrot_pkg.sv =====
// ----------------------------------------------------------------------------
// vrot_pkg: shared types and constants for the axis rotation core
// Holds the axis codes, the fixed CORDIC gain inverse, the arctangent table
// and the side-band tag that travels beside the rotating pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vrot_pkg;

    // Axis codes of the axis field
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Field widths fixed by the interface
    localparam int unsigned FIELD_W = 32;
    localparam int unsigned ANGLE_W = 32;

    // Number of arctangent entries available to the cell chain
    localparam int unsigned ATAN_LEN = 40;

    // Inverse CORDIC gain at its limit, scaled by 2^32
    localparam logic [31:0] GAIN_INV = 32'd2608131496;

    // round(atan(2^-i) * 2^32 / (2*pi))
    localparam logic [ANGLE_W-1:0] ATAN_TAB [0:ATAN_LEN-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0,
        32'd0,         32'd0,         32'd0,         32'd0,
        32'd0,         32'd0,         32'd0,         32'd0
    };

    // Side-band of one transaction in flight: valid, axis and the
    // sign-extended input vector (passing component and unused-axis copy)
    typedef struct packed {
        logic               valid;
        logic [1:0]         axis;
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic [FIELD_W-1:0] z;
    } vrot_tag_t;

endpackage

`default_nettype wire

// ===== rtl/core/vrot_prescale.sv =====
// ----------------------------------------------------------------------------
// vrot_prescale: pair select, gain scaling and quadrant fold
// Two register stages: the first picks the turning pair and scales it by the
// inverse gain, the second folds the angle into [-1/4, 1/4) turn.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vrot_prescale #(
    parameter int unsigned CW = 32,
    parameter int unsigned DW = CW + 18
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic                                take,
    input  wire logic [1:0]                          axis,
    input  wire logic [vrot_pkg::FIELD_W-1:0]        x_in,
    input  wire logic [vrot_pkg::FIELD_W-1:0]        y_in,
    input  wire logic [vrot_pkg::FIELD_W-1:0]        z_in,
    input  wire logic [vrot_pkg::ANGLE_W-1:0]        turn_angle,
    output logic signed [DW-1:0]                     a_out,
    output logic signed [DW-1:0]                     b_out,
    output logic signed [vrot_pkg::ANGLE_W-1:0]      z_out,
    output vrot_pkg::vrot_tag_t                      tag_out
);

    localparam logic signed [CW+32:0] GAIN_S = (CW+33)'(vrot_pkg::GAIN_INV);

    logic signed [CW-1:0]               xs, ys, zs;
    logic signed [CW-1:0]               a_sel, b_sel;
    logic signed [CW+32:0]              prod_a, prod_b;
    vrot_pkg::vrot_tag_t                tag1_next, tag1_reg, tag2_reg;
    logic signed [DW-1:0]               a1_next, b1_next, a1_reg, b1_reg;
    logic [vrot_pkg::ANGLE_W-1:0]       ang1_reg;
    logic                               fold;
    logic signed [DW-1:0]               a2_next, b2_next, a2_reg, b2_reg;
    logic signed [vrot_pkg::ANGLE_W-1:0] z2_next, z2_reg;

    // Sign-extend the low CW bits of each coordinate
    assign xs = x_in[CW-1:0];
    assign ys = y_in[CW-1:0];
    assign zs = z_in[CW-1:0];

    // Pick the turning pair for the axis
    always_comb
    begin
        unique case (axis)
            vrot_pkg::AXIS_X:
            begin
                a_sel = ys;
                b_sel = zs;
            end
            vrot_pkg::AXIS_Y:
            begin
                a_sel = zs;
                b_sel = xs;
            end
            default:
            begin
                a_sel = xs;
                b_sel = ys;
            end
        endcase
    end

    // Scale by the inverse gain, keep 32 fraction bits
    assign prod_a  = (CW+33)'(a_sel) * GAIN_S;
    assign prod_b  = (CW+33)'(b_sel) * GAIN_S;
    assign a1_next = DW'($signed(prod_a[CW+32:16]));
    assign b1_next = DW'($signed(prod_b[CW+32:16]));

    always_comb
    begin
        tag1_next.valid = take;
        tag1_next.axis  = axis;
        tag1_next.x     = vrot_pkg::FIELD_W'(xs);
        tag1_next.y     = vrot_pkg::FIELD_W'(ys);
        tag1_next.z     = vrot_pkg::FIELD_W'(zs);
    end

    // Fold quadrants 1 and 2: negate the pair and turn the angle by a half
    assign fold    = ang1_reg[31] ^ ang1_reg[30];
    assign a2_next = fold ? -a1_reg : a1_reg;
    assign b2_next = fold ? -b1_reg : b1_reg;
    assign z2_next = {ang1_reg[31] ^ fold, ang1_reg[30:0]};

    // Hold the tags; valid bits clear on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else if (en)
        begin
            tag1_reg <= tag1_next;
            tag2_reg <= tag1_reg;
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg   <= a1_next;
            b1_reg   <= b1_next;
            ang1_reg <= turn_angle;
            a2_reg   <= a2_next;
            b2_reg   <= b2_next;
            z2_reg   <= z2_next;
        end
    end

    assign a_out   = a2_reg;
    assign b_out   = b2_reg;
    assign z_out   = z2_reg;
    assign tag_out = tag2_reg;

endmodule

`default_nettype wire

// ===== rtl/core/vrot_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// vrot_cordic_cell: one CORDIC micro-rotation
// Turns the pair by +/- atan(2^-SHIFT) toward a zero residual angle and
// hands the pair, residual and tag to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vrot_cordic_cell #(
    parameter int unsigned DW    = 50,
    parameter int unsigned SHIFT = 0
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic signed [DW-1:0]                a_in,
    input  wire logic signed [DW-1:0]                b_in,
    input  wire logic signed [vrot_pkg::ANGLE_W-1:0] z_in,
    input  vrot_pkg::vrot_tag_t                      tag_in,
    output logic signed [DW-1:0]                     a_out,
    output logic signed [DW-1:0]                     b_out,
    output logic signed [vrot_pkg::ANGLE_W-1:0]      z_out,
    output vrot_pkg::vrot_tag_t                      tag_out
);

    localparam logic signed [vrot_pkg::ANGLE_W-1:0] STEP_ANGLE =
        $signed(vrot_pkg::ATAN_TAB[SHIFT]);

    logic signed [DW-1:0]               da, db;
    logic signed [DW-1:0]               a_next, b_next, a_reg, b_reg;
    logic signed [vrot_pkg::ANGLE_W-1:0] z_next, z_reg;
    vrot_pkg::vrot_tag_t                tag_reg;

    assign da = b_in >>> SHIFT;
    assign db = a_in >>> SHIFT;

    // Rotate counter-clockwise on a non-negative residual, else clockwise
    always_comb
    begin
        if (!z_in[vrot_pkg::ANGLE_W-1])
        begin
            a_next = a_in - da;
            b_next = b_in + db;
            z_next = z_in - STEP_ANGLE;
        end
        else
        begin
            a_next = a_in + da;
            b_next = b_in - db;
            z_next = z_in + STEP_ANGLE;
        end
    end

    // Hold the tag; valid clears on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            z_reg <= z_next;
        end
    end

    assign a_out   = a_reg;
    assign b_out   = b_reg;
    assign z_out   = z_reg;
    assign tag_out = tag_reg;

endmodule

`default_nettype wire

// ===== rtl/core/vrot_finish.sv =====
// ----------------------------------------------------------------------------
// vrot_finish: rounding, saturation, axis mapping and output skid
// Rounds the turned pair to 16 fraction bits, clamps it to the coordinate
// range, puts it back on its axes and buffers it in an output register plus
// a skid register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vrot_finish #(
    parameter int unsigned CW = 32,
    parameter int unsigned DW = CW + 18
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic signed [DW-1:0]           a_in,
    input  wire logic signed [DW-1:0]           b_in,
    input  vrot_pkg::vrot_tag_t                 tag_in,
    output logic                                en,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [vrot_pkg::FIELD_W-1:0]        x_out,
    output logic [vrot_pkg::FIELD_W-1:0]        y_out,
    output logic [vrot_pkg::FIELD_W-1:0]        z_out,
    output logic                                overflow
);

    localparam int unsigned FW = vrot_pkg::FIELD_W;
    localparam logic signed [DW-1:0] HALF_LSB = DW'(32'sd32768);

    // Round half up to 16 fraction bits, clamp to CW bits, widen to a field
    function automatic logic [FW:0] round_sat(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] t;
        logic [DW-17:0]       r;
        logic signed [CW-1:0] c;
        logic                 ovf;
        t   = v + HALF_LSB;
        r   = t[DW-1:16];
        ovf = !((&r[DW-17:CW-1]) || !(|r[DW-17:CW-1]));
        if (ovf)
        begin
            c = r[DW-17] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        else
        begin
            c = r[CW-1:0];
        end
        return {ovf, FW'(c)};
    endfunction

    logic [FW:0]    ra, rb;
    logic [FW-1:0]  x_res, y_res, z_res;
    logic           ovf_res;
    logic           load;
    logic           take;
    logic           out_valid_reg, out_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    logic [FW-1:0]  x_out_reg, y_out_reg, z_out_reg;
    logic           ovf_out_reg;
    logic [FW-1:0]  x_skid_reg, y_skid_reg, z_skid_reg;
    logic           ovf_skid_reg;

    assign ra = round_sat(a_in);
    assign rb = round_sat(b_in);

    // Put the turned pair back on its axes
    always_comb
    begin
        x_res   = tag_in.x;
        y_res   = tag_in.y;
        z_res   = tag_in.z;
        ovf_res = ra[FW] | rb[FW];
        unique case (tag_in.axis)
            vrot_pkg::AXIS_X:
            begin
                y_res = ra[FW-1:0];
                z_res = rb[FW-1:0];
            end
            vrot_pkg::AXIS_Y:
            begin
                z_res = ra[FW-1:0];
                x_res = rb[FW-1:0];
            end
            vrot_pkg::AXIS_Z:
            begin
                x_res = ra[FW-1:0];
                y_res = rb[FW-1:0];
            end
            default:
            begin
                ovf_res = 1'b0;
            end
        endcase
    end

    // Advance the pipeline while the skid register is free
    assign en   = !skid_valid_reg;
    assign load = tag_in.valid && en;
    assign take = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || take)
        begin
            out_valid_next  = skid_valid_reg || load;
            skid_valid_next = 1'b0;
        end
        else if (load)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Refill the output register from the skid first, else from the pipeline;
    // park a result in the skid while the output is stalled
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                x_out_reg   <= x_skid_reg;
                y_out_reg   <= y_skid_reg;
                z_out_reg   <= z_skid_reg;
                ovf_out_reg <= ovf_skid_reg;
            end
            else
            begin
                x_out_reg   <= x_res;
                y_out_reg   <= y_res;
                z_out_reg   <= z_res;
                ovf_out_reg <= ovf_res;
            end
        end
        else if (load)
        begin
            x_skid_reg   <= x_res;
            y_skid_reg   <= y_res;
            z_skid_reg   <= z_res;
            ovf_skid_reg <= ovf_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign x_out     = x_out_reg;
    assign y_out     = y_out_reg;
    assign z_out     = z_out_reg;
    assign overflow  = ovf_out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/vector_axis_rotation.sv =====
// ----------------------------------------------------------------------------
// vector_axis_rotation: rotate a 3D Q16.16 vector about the x, y or z axis
// Pipelined CORDIC: gain prescale, quadrant fold, a chain of micro-rotation
// cells, then rounding, saturation and an output skid buffer.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   input   | in_valid / in_ready  | axis, x_in, y_in, z_in, turn_angle
//   output  | out_valid / out_ready| x_out, y_out, z_out, overflow
//
// One transaction enters every cycle while in_ready is high; the registers are
// the prescale multiply, quadrant fold, one cell per CORDIC stage, output reg.
// rst_n clears all valid bits and the skid buffer; datapath is not reset.
// A stalled output fills the skid register; in_ready then drops and the
// whole chain holds until the output register is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vector_axis_rotation #(
    parameter int unsigned COORD_WIDTH  = 32,
    parameter int unsigned ANGLE_STAGES = 24
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     axis,
    input  wire logic [vrot_pkg::FIELD_W-1:0]   x_in,
    input  wire logic [vrot_pkg::FIELD_W-1:0]   y_in,
    input  wire logic [vrot_pkg::FIELD_W-1:0]   z_in,
    input  wire logic [vrot_pkg::ANGLE_W-1:0]   turn_angle,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [vrot_pkg::FIELD_W-1:0]        x_out,
    output logic [vrot_pkg::FIELD_W-1:0]        y_out,
    output logic [vrot_pkg::FIELD_W-1:0]        z_out,
    output logic                                overflow
);

    localparam int unsigned CW = (COORD_WIDTH > vrot_pkg::FIELD_W) ?
                                 vrot_pkg::FIELD_W : COORD_WIDTH;
    localparam int unsigned DW = CW + 18;
    localparam int unsigned NSTAGE = (ANGLE_STAGES > vrot_pkg::ATAN_LEN) ?
                                     vrot_pkg::ATAN_LEN : ANGLE_STAGES;

    logic                                en;
    logic                                take;
    logic signed [DW-1:0]                a_pipe [0:NSTAGE];
    logic signed [DW-1:0]                b_pipe [0:NSTAGE];
    logic signed [vrot_pkg::ANGLE_W-1:0] z_pipe [0:NSTAGE];
    vrot_pkg::vrot_tag_t                 tag_pipe [0:NSTAGE];

    assign in_ready = en;
    assign take     = in_valid && en;

    // Select, scale and fold
    vrot_prescale #(
        .CW (CW),
        .DW (DW)
    ) u_prescale (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .take       (take),
        .axis       (axis),
        .x_in       (x_in),
        .y_in       (y_in),
        .z_in       (z_in),
        .turn_angle (turn_angle),
        .a_out      (a_pipe[0]),
        .b_out      (b_pipe[0]),
        .z_out      (z_pipe[0]),
        .tag_out    (tag_pipe[0])
    );

    // Chain of micro-rotation cells
    for (genvar i = 0; i < NSTAGE; i++)
    begin : g_cell
        vrot_cordic_cell #(
            .DW    (DW),
            .SHIFT (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .a_in    (a_pipe[i]),
            .b_in    (b_pipe[i]),
            .z_in    (z_pipe[i]),
            .tag_in  (tag_pipe[i]),
            .a_out   (a_pipe[i+1]),
            .b_out   (b_pipe[i+1]),
            .z_out   (z_pipe[i+1]),
            .tag_out (tag_pipe[i+1])
        );
    end

    // Round, saturate, map back and buffer
    vrot_finish #(
        .CW (CW),
        .DW (DW)
    ) u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .a_in      (a_pipe[NSTAGE]),
        .b_in      (b_pipe[NSTAGE]),
        .tag_in    (tag_pipe[NSTAGE]),
        .en        (en),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .x_out     (x_out),
        .y_out     (y_out),
        .z_out     (z_out),
        .overflow  (overflow)
    );

endmodule

`default_nettype wire
